// ===== sv/bm3_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bm3_pkg
// Shared types and constants for the 3x3 binary morphology block.
// ----------------------------------------------------------------------------
package bm3_pkg;

  // configuration port
  localparam int REG_W     = 11;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE         = 2'd2;

  localparam logic [REG_W-1:0] WIDTH_RESET  = 11'd1024;
  localparam logic [REG_W-1:0] HEIGHT_RESET = 11'd1024;

  localparam logic MODE_ERODE  = 1'b0;
  localparam logic MODE_DILATE = 1'b1;

  // smallest frame dimension
  localparam int MIN_DIM = 3;

  // one column of the line stores: b is two rows up, a is one row up
  typedef struct packed {
    logic b;
    logic a;
  } line_entry_t;

  // one result item
  typedef struct packed {
    logic last;
    logic pixel;
  } out_item_t;

endpackage

// ===== sv/binary_morphology_3x3.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_morphology_3x3
// 3x3 square erosion / dilation over a raster stream of one-bit pixels.
// Two line stores share one RAM; the window stage reads, shifts and writes
// back one column per pixel. Border pixels pass through unchanged.
// ----------------------------------------------------------------------------
//  channel   direction  fields (low bit up)
//  s_axis    in         tdata: pixel_in        tuser: filler
//  m_axis    out        tdata: pixel_out       tlast: frame_last
//  cfg       in         index 0 image_width, 1 image_height, 2 mode
//
// One pixel per cycle while s_axis_tready is high: the request is read from
// the line RAM in its accept cycle and the window is updated and written
// back the next cycle; a write to the same column in the cycle before is
// forwarded around the RAM. A result passes the window stage registers and
// the output buffer before it appears on m_axis. After reset a clearing pass
// zeros the line RAM; s_axis_tready stays low meanwhile. Otherwise input
// stalls only when the three-entry buffer cannot hold the results in flight.
// ----------------------------------------------------------------------------
module binary_morphology_3x3
  import bm3_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  // stream in
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,   // [0] pixel_in
  input  logic                 s_axis_tuser,   // [0] filler
  // stream out
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [7:0]           m_axis_tdata,   // [0] pixel_out
  output logic                 m_axis_tlast,   // frame_last
  // configuration
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_data
);

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int CW1  = $clog2(MAX_WIDTH + 1);
  localparam int HW   = $clog2(MAX_HEIGHT + 1);
  localparam int RW   = $clog2(MAX_HEIGHT + 2);
  localparam int EWW  = (REG_W > CW1) ? REG_W : CW1;
  localparam int EHW  = (REG_W > HW) ? REG_W : HW;

  // configuration registers
  logic [REG_W-1:0] image_width;
  logic [REG_W-1:0] image_height;
  logic             mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
      mode         <= MODE_ERODE;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:  image_width  <= cfg_data;
        CFG_IMAGE_HEIGHT: image_height <= cfg_data;
        CFG_MODE:         mode         <= cfg_data[0];
        default:          ;
      endcase
    end
  end

  // saturated frame size
  logic [CW1-1:0] w_eff;
  logic [HW-1:0]  h_eff;
  logic [EWW-1:0] w_ext;
  logic [EHW-1:0] h_ext;

  always_comb begin
    w_ext = EWW'(image_width);
    h_ext = EHW'(image_height);
    if (w_ext < EWW'(MIN_DIM))        w_eff = CW1'(MIN_DIM);
    else if (w_ext > EWW'(MAX_WIDTH)) w_eff = CW1'(MAX_WIDTH);
    else                              w_eff = CW1'(w_ext);
    if (h_ext < EHW'(MIN_DIM))         h_eff = HW'(MIN_DIM);
    else if (h_ext > EHW'(MAX_HEIGHT)) h_eff = HW'(MAX_HEIGHT);
    else                               h_eff = HW'(h_ext);
  end

  // clearing pass over the line RAM
  logic          clr_active;
  logic [CW-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_addr   <= '0;
    end else if (clr_active) begin
      clr_addr <= clr_addr + CW'(1);
      if (clr_addr == CW'(MAX_WIDTH - 1)) begin
        clr_active <= 1'b0;
      end
    end
  end

  // handshake
  logic       s1_v;
  logic [1:0] fifo_count;
  logic       accept;

  assign s_axis_tready = !clr_active && ((3'(fifo_count) + 3'(s1_v)) <= 3'd2);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // position tracking at accept time
  logic [CW-1:0] column_count;
  logic [RW-1:0] row_count;
  logic [RW-1:0] ro;
  logic [CW1-1:0] co;
  logic [RW:0]   ro_x;
  logic [RW:0]   h_x;
  logic [RW:0]   ri_inc;
  logic [CW:0]   ci_inc;
  logic          pos_ok;
  logic          has_result;
  logic          is_last;
  logic          is_interior;
  logic [CW-1:0] column_next;
  logic [RW-1:0] row_next;

  always_comb begin
    // window centre sits one row and one column behind the input
    if (column_count != '0) begin
      pos_ok = (row_count != '0);
      ro     = row_count - RW'(1);
      co     = CW1'(column_count) - CW1'(1);
    end else begin
      pos_ok = (row_count >= RW'(2));
      ro     = row_count - RW'(2);
      co     = w_eff - CW1'(1);
    end
    ro_x        = {1'b0, ro};
    h_x         = (RW + 1)'(h_eff);
    has_result  = pos_ok && (ro_x < h_x) && (co < w_eff);
    is_interior = (ro != '0) && ((ro_x + (RW + 1)'(2)) <= h_x) && (co != '0) &&
                  (({1'b0, co} + (CW1 + 1)'(2)) <= {1'b0, w_eff});
    is_last     = (ro_x == h_x - (RW + 1)'(1)) && (co == w_eff - CW1'(1));

    ci_inc = {1'b0, column_count} + (CW + 1)'(1);
    ri_inc = {1'b0, row_count};
    if (ci_inc >= (CW + 1)'(w_eff)) begin
      column_next = '0;
      ri_inc      = ri_inc + (RW + 1)'(1);
    end else begin
      column_next = ci_inc[CW-1:0];
    end
    row_next = ri_inc[RW-1:0];
    if (ri_inc > h_x + (RW + 1)'(1)) begin
      column_next = '0;
      row_next    = '0;
    end
    if (has_result && is_last) begin
      column_next = '0;
      row_next    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      column_count <= column_next;
      row_count    <= row_next;
    end
  end

  // window stage registers
  logic          s1_cur;
  logic [CW-1:0] s1_addr;
  logic          s1_res;
  logic          s1_last;
  logic          s1_interior;
  logic          s1_fwd;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else begin
      s1_v <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cur      <= s_axis_tuser ? 1'b0 : s_axis_tdata[0];
      s1_addr     <= column_count;
      s1_res      <= has_result;
      s1_last     <= is_last;
      s1_interior <= is_interior;
      // previous request writes this column at the same edge as our read
      s1_fwd      <= s1_v && (s1_addr == column_count);
    end
  end

  // line RAM
  line_entry_t   rd_data;
  line_entry_t   wr_last;
  line_entry_t   entry;
  line_entry_t   entry_next;
  logic          mem_we;
  logic [CW-1:0] mem_waddr;
  line_entry_t   mem_wdata;

  assign entry        = s1_fwd ? wr_last : rd_data;
  assign entry_next.b = entry.a;
  assign entry_next.a = s1_cur;

  assign mem_we    = clr_active || s1_v;
  assign mem_waddr = clr_active ? clr_addr : s1_addr;
  assign mem_wdata = clr_active ? line_entry_t'('0) : entry_next;

  bm3_line_mem #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_line_mem (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (column_count),
    .rd_data (rd_data),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata)
  );

  always_ff @(posedge clk) begin
    if (s1_v) begin
      wr_last <= entry_next;
    end
  end

  // 3x3 window, newest column in the low bits
  logic [8:0] window_bits;
  logic [8:0] window_next;
  logic       result;
  out_item_t  fifo_din;

  assign window_next = {window_bits[5:0], s1_cur, entry.a, entry.b};

  always_ff @(posedge clk) begin
    if (rst) begin
      window_bits <= '0;
    end else if (s1_v) begin
      window_bits <= window_next;
    end
  end

  always_comb begin
    if (!s1_interior)           result = window_next[4];
    else if (mode == MODE_ERODE) result = &window_next;
    else                        result = |window_next;
  end

  assign fifo_din.pixel = result;
  assign fifo_din.last  = s1_last;

  out_item_t fifo_dout;

  bm3_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (s1_v && s1_res),
    .din       (fifo_din),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .dout      (fifo_dout),
    .count     (fifo_count)
  );

  assign m_axis_tdata = {7'd0, fifo_dout.pixel};
  assign m_axis_tlast = fifo_dout.last;

endmodule

// ===== sv/bm3_line_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bm3_line_mem
// Two line stores side by side in one simple dual-port RAM, registered read.
// ----------------------------------------------------------------------------
module bm3_line_mem
  import bm3_pkg::*;
#(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output line_entry_t   rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  line_entry_t   wr_data
);

  line_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read during write to the same entry returns the old contents
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== sv/bm3_out_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bm3_out_fifo
// Three-entry result buffer between the window stage and the output stream.
// ----------------------------------------------------------------------------
module bm3_out_fifo
  import bm3_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  out_item_t din,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t dout,
  output logic [1:0] count
);

  out_item_t  slots [3];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic       pop;

  assign out_valid = (count != 2'd0);
  assign pop       = out_valid && out_ready;
  assign dout      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == 2'd2) ? 2'd0 : wr_ptr + 2'd1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == 2'd2) ? 2'd0 : rd_ptr + 2'd1;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the 3x3 binary erosion / dilation block. A short
// table of hand-made frames comes first, then a frame with out-of-range sizes,
// then random frames with random sizes, modes, flush lengths and register
// changes inside a frame. Every result is compared in order, against values
// written in the table or a pixel-accurate software copy of the block, and
// both stream sides stall at random.
// ----------------------------------------------------------------------------
module testbench
  import bm3_pkg::*;
();

  localparam int MAX_W         = 1024;
  localparam int MAX_H         = 1024;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_ITEMS  = 1650;
  localparam int QUIET_TAIL    = 300;

  typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_t;
  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_RESULT} row_check_t;
  typedef enum logic [1:0] {CUT_NONE, CUT_PAUSE, CUT_WIDTH, CUT_HEIGHT} cut_kind_t;
  typedef enum logic [1:0] {FLUSH_FULL, FLUSH_SHORT, FLUSH_LONG} flush_kind_t;

  typedef struct {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [REG_W-1:0]      val;
    logic                  px;
    logic                  fl;
    row_check_t            chk;
    out_item_t             res;
  } stim_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata = '0;   // [0] pixel_in
  logic                 s_axis_tuser = 1'b0; // [0] filler
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [7:0]           m_axis_tdata;        // [0] pixel_out
  logic                 m_axis_tlast;        // frame_last
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_IMAGE_WIDTH;
  logic [REG_W-1:0]     cfg_data = '0;

  binary_morphology_3x3 #(
    .MAX_WIDTH  (MAX_W),
    .MAX_HEIGHT (MAX_H)
  ) u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // shadow copy of the block
  bit [MAX_W-1:0]   row_above1;
  bit [MAX_W-1:0]   row_above2;
  bit [8:0]         window;
  int               col_pos = 0;
  int               row_pos = 0;
  logic [REG_W-1:0] reg_width  = WIDTH_RESET;
  logic [REG_W-1:0] reg_height = HEIGHT_RESET;
  logic             reg_mode   = MODE_ERODE;

  out_item_t expected_pixels [$];
  stim_row_t directed_tab [$];
  int        fail_count = 0;
  int        items_sent = 0;
  int        stall_left = 0;
  bit        src_idle_en = 1'b1;
  bit        sink_idle_en = 1'b1;
  out_item_t want;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic int clamp_dim(logic [REG_W-1:0] v, int hi);
    if (v < MIN_DIM) return MIN_DIM;
    if (v > hi) return hi;
    return int'(v);
  endfunction

  // one input item through the shadow copy; hit says whether it yields a result
  task automatic morph_predict(input logic px, input logic fl, output logic hit,
                               output out_item_t res);
    int   w, h, ci, ri, ro, co;
    logic cur, up1, up2, inner, last;
    w = clamp_dim(reg_width, MAX_W);
    h = clamp_dim(reg_height, MAX_H);
    ci = col_pos;
    ri = row_pos;
    cur = fl ? 1'b0 : px;
    up1 = 1'b0;
    up2 = 1'b0;
    ro = 0;
    co = 0;
    hit = 1'b0;
    last = 1'b0;
    res = '0;
    if (ci < MAX_W) begin
      up2 = row_above2[ci];
      up1 = row_above1[ci];
      row_above2[ci] = up1;
      row_above1[ci] = cur;
    end
    window = {window[5:0], cur, up1, up2};
    // window center trails the input by one row and one column
    if (ci >= 1) begin
      if (ri >= 1) begin
        ro = ri - 1;
        co = ci - 1;
        hit = 1'b1;
      end
    end else if (ri >= 2) begin
      ro = ri - 2;
      co = w - 1;
      hit = 1'b1;
    end
    if (hit && (ro >= h || co >= w)) hit = 1'b0;
    if (hit) begin
      inner = ro >= 1 && ro + 2 <= h && co >= 1 && co + 2 <= w;
      last = (ro == h - 1) && (co == w - 1);
      if (!inner) res.pixel = window[4];
      else if (reg_mode == MODE_ERODE) res.pixel = &window;
      else res.pixel = |window;
      res.last = last;
    end
    if (hit && last) begin
      col_pos = 0;
      row_pos = 0;
    end else begin
      ci++;
      if (ci >= w) begin
        ci = 0;
        ri++;
      end
      if (ri > h + 1) begin
        ci = 0;
        ri = 0;
      end
      col_pos = ci;
      row_pos = ri;
    end
  endtask

  // entered and left at a rising edge; ready is sampled at the falling edge
  task automatic send_item(input logic px, input logic fl, input bit use_model);
    logic      taken, hit;
    out_item_t res;
    if (src_idle_en && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'b0, px};
    s_axis_tuser  <= fl;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = s_axis_tready;
      @(posedge clk);
    end
    items_sent++;
    morph_predict(px, fl, hit, res);
    if (use_model && hit) expected_pixels.push_back(res);
  endtask

  task automatic hold_until_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] val);
    hold_until_drained();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_IMAGE_WIDTH:  reg_width  = val;
      CFG_IMAGE_HEIGHT: reg_height = val;
      CFG_MODE:         reg_mode   = val[0];
      default: ;
    endcase
  endtask

  // mostly small rows, now and then wider or out of range
  function automatic logic [REG_W-1:0] pick_width();
    if ($urandom_range(0, 9) == 0) return REG_W'($urandom_range(0, 2));
    if ($urandom_range(0, 7) == 0) return REG_W'($urandom_range(13, 40));
    return REG_W'($urandom_range(3, 12));
  endfunction

  function automatic logic [REG_W-1:0] pick_height();
    if ($urandom_range(0, 9) == 0) return REG_W'($urandom_range(0, 2));
    return REG_W'($urandom_range(3, 8));
  endfunction

  // one frame of random pixels (dens of 16 set) followed by its flush
  task automatic run_frame(input int dens, input flush_kind_t fk, input cut_kind_t ck);
    int fw, fh, total, cut, flush_n;
    fw = clamp_dim(reg_width, MAX_W);
    fh = clamp_dim(reg_height, MAX_H);
    total = fw * fh;
    cut = (ck != CUT_NONE) ? $urandom_range(1, total - 1) : -1;
    case (fk)
      FLUSH_SHORT: flush_n = $urandom_range(0, fw);
      FLUSH_LONG:  flush_n = fw + 1 + $urandom_range(1, fw);
      default:     flush_n = fw + 1;
    endcase
    for (int i = 0; i < total; i++) begin
      if (i == cut) begin
        case (ck)
          CUT_PAUSE:  hold_until_drained();
          CUT_WIDTH:  write_reg(CFG_IMAGE_WIDTH, pick_width());
          CUT_HEIGHT: write_reg(CFG_IMAGE_HEIGHT, pick_height());
          default: ;
        endcase
      end
      send_item($urandom_range(0, 15) < dens, $urandom_range(0, 39) == 0, 1'b1);
    end
    for (int i = 0; i < flush_n; i++) send_item(1'($urandom_range(0, 1)), 1'b1, 1'b1);
  endtask

  function automatic void tab_cfg(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] val);
    stim_row_t r;
    r = '{kind: ROW_CFG, idx: idx, val: val, px: 1'b0, fl: 1'b0, chk: CHK_NONE,
          res: '0};
    directed_tab.push_back(r);
  endfunction

  function automatic void tab_item(logic px, logic fl, row_check_t chk, logic pix,
                                   logic last);
    stim_row_t r;
    r = '{kind: ROW_ITEM, idx: '0, val: '0, px: px, fl: fl, chk: chk,
          res: '{last: last, pixel: pix}};
    directed_tab.push_back(r);
  endfunction

  // output side: random back-pressure bursts
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (sink_idle_en && $urandom_range(0, 7) == 0) begin
      stall_left    <= $urandom_range(0, 8);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // values seen at the falling edge are the ones taken at the next rising edge
  always @(negedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_pixels.size() == 0) begin
        $error("unexpected result: pixel_out %0b frame_last %0b",
               m_axis_tdata[0], m_axis_tlast);
        fail_count++;
      end else begin
        want = expected_pixels.pop_front();
        if (m_axis_tdata[0] !== want.pixel) begin
          $error("pixel_out mismatch: expected %0b actual %0b", want.pixel, m_axis_tdata[0]);
          fail_count++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("frame_last mismatch: expected %0b actual %0b", want.last, m_axis_tlast);
          fail_count++;
        end
      end
    end
  end

  initial begin
    logic        ready_seen;
    int          start_items, dens;
    logic        mode_sel;
    flush_kind_t fk;
    cut_kind_t   ck;

    // 3x3 all ones, erosion: warm-up gives nothing, then every pixel is 1
    tab_cfg(CFG_IMAGE_WIDTH, REG_W'(3));
    tab_cfg(CFG_IMAGE_HEIGHT, REG_W'(3));
    tab_cfg(CFG_MODE, REG_W'(MODE_ERODE));
    repeat (4) tab_item(1'b1, 1'b0, CHK_NONE, 1'b0, 1'b0);
    repeat (5) tab_item(1'b1, 1'b0, CHK_RESULT, 1'b1, 1'b0);
    repeat (3) tab_item(1'b1, 1'b1, CHK_RESULT, 1'b1, 1'b0);
    tab_item(1'b1, 1'b1, CHK_RESULT, 1'b1, 1'b1);
    // dilation, with a filler inside the frame that must read as a clear pixel
    tab_cfg(CFG_MODE, REG_W'(MODE_DILATE));
    repeat (4) tab_item(1'b0, 1'b0, CHK_MODEL, 1'b0, 1'b0);
    tab_item(1'b1, 1'b1, CHK_MODEL, 1'b0, 1'b0);
    repeat (3) tab_item(1'b0, 1'b0, CHK_MODEL, 1'b0, 1'b0);
    tab_item(1'b1, 1'b0, CHK_MODEL, 1'b0, 1'b0);
    tab_item(1'b0, 1'b1, CHK_MODEL, 1'b0, 1'b0);
    repeat (3) tab_item(1'b1, 1'b1, CHK_MODEL, 1'b0, 1'b0);

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    // line RAM clearing pass
    ready_seen = 1'b0;
    while (!ready_seen) begin
      @(negedge clk);
      ready_seen = s_axis_tready;
      @(posedge clk);
    end

    foreach (directed_tab[i]) begin
      if (directed_tab[i].kind == ROW_CFG) begin
        write_reg(directed_tab[i].idx, directed_tab[i].val);
      end else begin
        send_item(directed_tab[i].px, directed_tab[i].fl, directed_tab[i].chk == CHK_MODEL);
        if (directed_tab[i].chk == CHK_RESULT) expected_pixels.push_back(directed_tab[i].res);
      end
    end

    // out-of-range sizes saturate to the smallest frame
    write_reg(CFG_IMAGE_WIDTH, REG_W'(1));
    write_reg(CFG_IMAGE_HEIGHT, REG_W'(0));
    run_frame(8, FLUSH_FULL, CUT_NONE);

    start_items = items_sent;
    while (items_sent - start_items < RANDOM_ITEMS) begin
      if (items_sent - start_items > RANDOM_ITEMS - QUIET_TAIL) begin
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
      end else begin
        src_idle_en  = $urandom_range(0, 3) != 0;
        sink_idle_en = $urandom_range(0, 3) != 0;
      end
      if ($urandom_range(0, 9) == 0) begin
        // noise: random pixels and fillers with no frame structure
        repeat ($urandom_range(5, 30)) begin
          send_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b1);
        end
      end else begin
        write_reg(CFG_IMAGE_WIDTH, pick_width());
        write_reg(CFG_IMAGE_HEIGHT, pick_height());
        mode_sel = 1'($urandom_range(0, 1));
        write_reg(CFG_MODE, REG_W'(mode_sel));
        // erosion needs dense frames to produce ones, dilation sparse ones
        if ($urandom_range(0, 5) == 0) dens = $urandom_range(0, 16);
        else if (mode_sel == MODE_ERODE) dens = $urandom_range(11, 16);
        else dens = $urandom_range(0, 3);
        case ($urandom_range(0, 7))
          0:       fk = FLUSH_SHORT;
          1:       fk = FLUSH_LONG;
          default: fk = FLUSH_FULL;
        endcase
        ck = ($urandom_range(0, 7) == 0) ? cut_kind_t'($urandom_range(1, 3)) : CUT_NONE;
        run_frame(dens, fk, ck);
      end
    end

    hold_until_drained();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
